// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion macros for the sorted list block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define SLID_ASSERT(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");
`define SLID_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define SLID_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define SLID_ASSERT(label, clk, rst, cond)
`define SLID_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define SLID_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: rtl/core/slid_pkg.sv
// ----------------------------------------------------------------------------
// slid_pkg
// Constants, codes and control types of the sorted list block.
// ----------------------------------------------------------------------------
package slid_pkg;

   localparam int CAPACITY = 16;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int IDX_W    = $clog2(CAPACITY);

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_DELETE = 2'd1;
   localparam logic [1:0] OP_LIST   = 2'd2;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_EMPTY    = 2'd1;
   localparam logic [1:0] ST_NOTFOUND = 2'd2;
   localparam logic [1:0] ST_FULL     = 2'd3;

   typedef struct packed {
      logic       exec;
      logic [1:0] op;
      logic       emit;
      logic       pop;
   } cmd_type;

   typedef struct packed {
      logic [CNT_W-1:0] count;
      logic             count_zero;
      logic             count_full;
      logic             list_final;
      logic             rsp_valid;
   } stat_type;

endpackage

// File: rtl/core/slid_if.sv
// ----------------------------------------------------------------------------
// slid_if
// Request and response channel interfaces of the sorted list block.
// ----------------------------------------------------------------------------
interface slid_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         op;
   logic signed [31:0] value;

   modport source (output valid, output op, output value, input ready);
   modport sink (input valid, input op, input value, output ready);
endinterface

interface slid_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         status;
   logic signed [31:0] entry;
   logic               last;

   modport source (output valid, output status, output entry, output last, input ready);
   modport sink (input valid, input status, input entry, input last, output ready);
endinterface

// File: rtl/core/sorted_list_insert_delete.sv
// ----------------------------------------------------------------------------
// sorted_list_insert_delete
// Ascending store of signed values with insert, delete and full list.
// ----------------------------------------------------------------------------
//  channel   direction  payload
//  req_ch    in         op, value
//  rsp_ch    out        status, entry, last
//
// Insert and delete run in the cycle of acceptance across all cells at once;
// the result is in the output register on the next cycle.
// A list spends its acceptance cycle and then emits one entry per cycle while the
// output register is free, so it holds the input until its last entry is emitted.
// A new item is taken once the list read-out ends and the output register
// is empty or being drained; a stalled response holds everything.
// Reset empties the store.
`include "assert_macros.svh"

module sorted_list_insert_delete (
   input logic       clock,
   input logic       reset,
   slid_req_if.sink  req_ch,
   slid_rsp_if.source rsp_ch
);

   slid_pkg::cmd_type  cmd;
   slid_pkg::stat_type stat;

   slid_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_op    (req_ch.op),
      .req_ready (req_ch.ready),
      .rsp_ready (rsp_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   slid_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_value  (req_ch.value),
      .stat       (stat),
      .rsp_status (rsp_ch.status),
      .rsp_entry  (rsp_ch.entry),
      .rsp_last   (rsp_ch.last)
   );

   assign rsp_ch.valid = stat.rsp_valid;

   `SLID_ASSERT(a_count_range, clock, reset,
      stat.count <= slid_pkg::CNT_W'(slid_pkg::CAPACITY))
   `SLID_ASSERT_IMPLY(a_ready_free, clock, reset, req_ch.ready, !rsp_ch.valid || rsp_ch.ready)
   `SLID_ASSERT_IMPLY(a_emit_exclusive, clock, reset, cmd.emit, !cmd.exec)
   `SLID_ASSERT_NEXT(a_insert_grows, clock, reset,
      cmd.exec && (cmd.op == slid_pkg::OP_INSERT) && !stat.count_full,
      stat.count == $past(stat.count) + slid_pkg::CNT_W'(1))

endmodule

// File: rtl/core/slid_datapath.sv
// ----------------------------------------------------------------------------
// slid_datapath
// Row of sorted value cells with parallel compare and shift, list read-out
// index and the registered response.
// ----------------------------------------------------------------------------
module slid_datapath (
   input  logic                        clock,
   input  logic                        reset,
   input  slid_pkg::cmd_type           cmd,
   input  logic signed [31:0]          req_value,
   output slid_pkg::stat_type          stat,
   output logic [1:0]                  rsp_status,
   output logic signed [31:0]          rsp_entry,
   output logic                        rsp_last
);

   logic signed [31:0] cells_ff [slid_pkg::CAPACITY];
   logic signed [31:0] ins_next [slid_pkg::CAPACITY];
   logic signed [31:0] del_next [slid_pkg::CAPACITY];
   logic [slid_pkg::CAPACITY-1:0] valid_v, ge_v, hit_v, ins_shift, del_shift;
   logic [slid_pkg::CNT_W-1:0] count_ff, count_in;
   logic [slid_pkg::IDX_W-1:0] idx_ff, idx_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [1:0] rsp_status_ff, rsp_status_in;
   logic signed [31:0] rsp_entry_ff, rsp_entry_in;
   logic rsp_last_ff, rsp_last_in;
   logic rsp_load, count_zero, count_full, found, list_final;
   logic do_insert, do_delete;

   assign count_zero = (count_ff == '0);
   assign count_full = (count_ff == slid_pkg::CNT_W'(slid_pkg::CAPACITY));
   assign list_final = (slid_pkg::CNT_W'(idx_ff) == (count_ff - slid_pkg::CNT_W'(1)));
   assign found      = |hit_v;

   always_comb begin
      for (int i = 0; i < slid_pkg::CAPACITY; i++) begin
         valid_v[i]   = slid_pkg::CNT_W'(i) < count_ff;
         ge_v[i]      = cells_ff[i] >= req_value;
         hit_v[i]     = valid_v[i] && (cells_ff[i] == req_value);
         ins_shift[i] = !valid_v[i] || ge_v[i];
         del_shift[i] = valid_v[i] && ge_v[i];
      end
      ins_next[0] = ins_shift[0] ? req_value : cells_ff[0];
      for (int i = 1; i < slid_pkg::CAPACITY; i++) begin
         if (!ins_shift[i]) begin
            ins_next[i] = cells_ff[i];
         end else if (!ins_shift[i-1]) begin
            ins_next[i] = req_value;
         end else begin
            ins_next[i] = cells_ff[i-1];
         end
      end
      for (int i = 0; i < slid_pkg::CAPACITY - 1; i++) begin
         del_next[i] = del_shift[i] ? cells_ff[i+1] : cells_ff[i];
      end
      del_next[slid_pkg::CAPACITY-1] = cells_ff[slid_pkg::CAPACITY-1];
   end

   assign do_insert = cmd.exec && (cmd.op == slid_pkg::OP_INSERT) && !count_full;
   assign do_delete = cmd.exec && (cmd.op == slid_pkg::OP_DELETE) && found;

   always_comb begin
      count_in = count_ff;
      if (do_insert) begin
         count_in = count_ff + slid_pkg::CNT_W'(1);
      end else if (do_delete) begin
         count_in = count_ff - slid_pkg::CNT_W'(1);
      end
   end

   always_comb begin
      idx_in = idx_ff;
      if (cmd.exec) begin
         idx_in = '0;
      end else if (cmd.emit) begin
         idx_in = idx_ff + slid_pkg::IDX_W'(1);
      end
   end

   always_comb begin
      rsp_load      = 1'b0;
      rsp_status_in = slid_pkg::ST_OK;
      rsp_entry_in  = '0;
      rsp_last_in   = 1'b1;
      if (cmd.exec) begin
         case (cmd.op)
            slid_pkg::OP_INSERT: begin
               rsp_load      = 1'b1;
               rsp_status_in = count_full ? slid_pkg::ST_FULL : slid_pkg::ST_OK;
            end
            slid_pkg::OP_DELETE: begin
               rsp_load = 1'b1;
               if (count_zero) begin
                  rsp_status_in = slid_pkg::ST_EMPTY;
               end else if (!found) begin
                  rsp_status_in = slid_pkg::ST_NOTFOUND;
               end
            end
            slid_pkg::OP_LIST: begin
               rsp_load      = count_zero;
               rsp_status_in = slid_pkg::ST_EMPTY;
            end
            default: begin
               rsp_load = 1'b0;
            end
         endcase
      end else if (cmd.emit) begin
         rsp_load     = 1'b1;
         rsp_entry_in = cells_ff[idx_ff];
         rsp_last_in  = list_final;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (cmd.pop) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_insert) begin
         cells_ff <= ins_next;
      end else if (do_delete) begin
         cells_ff <= del_next;
      end
      if (rsp_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_entry_ff  <= rsp_entry_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   assign stat.count      = count_ff;
   assign stat.count_zero = count_zero;
   assign stat.count_full = count_full;
   assign stat.list_final = list_final;
   assign stat.rsp_valid  = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry       = rsp_entry_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

// File: rtl/core/slid_ctrl.sv
// ----------------------------------------------------------------------------
// slid_ctrl
// Controller: accepts requests and steps the list read-out.
// ----------------------------------------------------------------------------
module slid_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic [1:0]         req_op,
   output logic               req_ready,
   input  logic               rsp_ready,
   input  slid_pkg::stat_type stat,
   output slid_pkg::cmd_type  cmd
);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_LIST = 1'b1;

   logic state_ff, state_in;
   logic out_free, accept;

   assign out_free  = !stat.rsp_valid || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && out_free;
   assign accept    = req_valid && req_ready;

   assign cmd.exec = accept;
   assign cmd.op   = req_op;
   assign cmd.emit = (state_ff == S_LIST) && out_free;
   assign cmd.pop  = stat.rsp_valid && rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept && (req_op == slid_pkg::OP_LIST) && !stat.count_zero) begin
               state_in = S_LIST;
            end
         end
         S_LIST: begin
            if (out_free && stat.list_final) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
